// File: rtl/core/onset_attack_decay_envelope_assert.svh
// assertion macros used by the envelope top module
`ifndef ONSET_ATTACK_DECAY_ENVELOPE_ASSERT_SVH
`define ONSET_ATTACK_DECAY_ENVELOPE_ASSERT_SVH

// same-cycle implication, ignored while reset is high
`define OADE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("envelope same-cycle check failed");

// next-cycle implication, ignored while reset is high
`define OADE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("envelope next-cycle check failed");

`endif

// File: rtl/core/oade_pkg.sv
package oade_pkg;

   // field widths
   localparam int SAMPLE_W   = 24;
   localparam int LEVEL_W    = 24;
   localparam int STEP_W     = 24;
   localparam int FRAC_W     = 23;
   localparam int CSR_ADDR_W = 2;

   // stereo lanes carried on the stream, and default active channel count
   localparam int LANES            = 2;
   localparam int CHANNELS_DEFAULT = 2;

   localparam int REQ_DATA_W = LANES * SAMPLE_W;
   localparam int RSP_DATA_W = LANES * SAMPLE_W + LEVEL_W;

   // q1.23 full scale
   localparam logic [LEVEL_W-1:0] FULL_SCALE = 24'h800000;

   // register reset values
   localparam logic [STEP_W-1:0]  ATTACK_STEP_RESET = 24'd839;
   localparam logic [STEP_W-1:0]  DECAY_STEP_RESET  = 24'd84;
   localparam logic [LEVEL_W-1:0] ONSET_LEVEL_RESET = 24'd0;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_ATTACK = 2'd1,
      PH_DECAY  = 2'd2
   } phase_type;

   typedef enum logic {
      OP_SAMPLE  = 1'b0,
      OP_NOTE_ON = 1'b1
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ATTACK_STEP = 2'd0,
      CSR_DECAY_STEP  = 2'd1,
      CSR_ONSET_LEVEL = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                  valid;
      logic [CSR_ADDR_W-1:0] index;
      logic [STEP_W-1:0]     data;
   } csr_write_type;

   typedef struct packed {
      phase_type          phase;
      logic [LEVEL_W-1:0] level;
      logic               attack_armed;
   } env_status_type;

endpackage

// File: rtl/core/oade_scale.sv
module oade_scale
   import oade_pkg::*;
(
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic        [LEVEL_W-1:0]  level,
   output logic signed [SAMPLE_W-1:0] scaled
);

   logic signed [SAMPLE_W+LEVEL_W:0] product;

   // signed sample times unsigned level, floor shift by the fraction width
   assign product = sample * $signed({1'b0, level});
   assign scaled  = product[FRAC_W+SAMPLE_W-1:FRAC_W];

endmodule

// File: rtl/core/oade_env_step.sv
module oade_env_step
   import oade_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                item_accept,
   input  logic                item_op,
   input  csr_write_type       csr,
   output logic [LEVEL_W-1:0]  sample_level,
   output env_status_type      status
);

   phase_type          phase_ff, phase_in, phase_step;
   logic [LEVEL_W-1:0] level_ff, level_in, level_step;
   logic [STEP_W-1:0]  attack_step_ff, attack_step_in;
   logic [STEP_W-1:0]  decay_step_ff, decay_step_in;
   logic [LEVEL_W-1:0] onset_level_ff, onset_level_in;
   logic [LEVEL_W:0]   attack_sum;

   assign attack_sum = {1'b0, level_ff} + {1'b0, attack_step_ff};

   // envelope step for one accepted item
   always_comb begin
      phase_step   = phase_ff;
      level_step   = level_ff;
      sample_level = '0;
      if (item_op == OP_NOTE_ON) begin
         if (attack_step_ff != '0) begin
            level_step = onset_level_ff;
            phase_step = PH_ATTACK;
         end else if (decay_step_ff != '0) begin
            level_step = FULL_SCALE;
            phase_step = PH_DECAY;
         end
      end else begin
         unique case (phase_ff)
            PH_ATTACK: begin
               if (attack_sum >= {1'b0, FULL_SCALE}) begin
                  level_step = FULL_SCALE;
                  phase_step = PH_DECAY;
               end else begin
                  level_step = attack_sum[LEVEL_W-1:0];
               end
               sample_level = level_step;
            end
            PH_DECAY: begin
               if (level_ff <= decay_step_ff) begin
                  level_step = '0;
                  phase_step = PH_IDLE;
               end else begin
                  level_step = level_ff - decay_step_ff;
               end
               sample_level = level_step;
            end
            default: begin
               sample_level = '0;
            end
         endcase
      end
   end

   // item step first, then register writes on top of it
   always_comb begin
      phase_in       = item_accept ? phase_step : phase_ff;
      level_in       = item_accept ? level_step : level_ff;
      attack_step_in = attack_step_ff;
      decay_step_in  = decay_step_ff;
      onset_level_in = onset_level_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_ATTACK_STEP: begin
               attack_step_in = csr.data;
               if (phase_in == PH_ATTACK && csr.data == '0) begin
                  phase_in = PH_IDLE;
               end
            end
            CSR_DECAY_STEP: begin
               decay_step_in = csr.data;
               if (phase_in == PH_DECAY && csr.data == '0) begin
                  phase_in = PH_IDLE;
               end
            end
            CSR_ONSET_LEVEL: begin
               onset_level_in = csr.data;
            end
            default: begin
               attack_step_in = attack_step_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         level_ff       <= '0;
         attack_step_ff <= ATTACK_STEP_RESET;
         decay_step_ff  <= DECAY_STEP_RESET;
         onset_level_ff <= ONSET_LEVEL_RESET;
      end else begin
         phase_ff       <= phase_in;
         level_ff       <= level_in;
         attack_step_ff <= attack_step_in;
         decay_step_ff  <= decay_step_in;
         onset_level_ff <= onset_level_in;
      end
   end

   assign status.phase        = phase_ff;
   assign status.level        = level_ff;
   assign status.attack_armed = (attack_step_ff != '0);

endmodule

// File: rtl/core/onset_attack_decay_envelope.sv
// Linear attack-decay envelope applied to a stereo sample stream.
// req channel: tuser is the opcode (sample tick or note-on), tdata the two
// input samples. A note-on loads the onset level and starts attack (or starts
// decay at full scale when only decay is on) and returns nothing. Each sample
// tick steps the envelope and returns one rsp transfer with both samples
// scaled by the new level and the level itself; in idle the outputs are zero.
// csr channel writes attack_step (0), decay_step (1), onset_level (2); other
// addresses are dropped. csr_ready is always high.
// A sample tick passes the stage register, then the output register, to rsp.
// Throughput: one item per cycle unless rsp_tready stalls the pipeline. The
// envelope update sits in front of a stage register, and one 24x25 multiply
// per lane sits between that stage and the output register.
// Stalls: when rsp_tready is low the result holds and the stage fills; req
// stays open until both the stage and the output register are occupied.
// Reset (synchronous, active high) clears the pipeline, sets phase to idle,
// level to zero and the registers to their defaults.
`include "onset_attack_decay_envelope_assert.svh"

module onset_attack_decay_envelope
   import oade_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // req: tdata = left_in[23:0], right_in[47:24]; tuser = opcode
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   // rsp: tdata = left_out[23:0], right_out[47:24], level_out[71:48]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [STEP_W-1:0]     csr_wdata
);

   logic                      req_xfer;
   logic                      s1_advance;
   csr_write_type             csr;
   env_status_type            status;
   logic [LEVEL_W-1:0]        sample_level;

   logic                      s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_W-1:0] s1_sample_ff [LANES];
   logic [LEVEL_W-1:0]        s1_level_ff;
   logic signed [SAMPLE_W-1:0] lane_scaled [LANES];

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   // handshakes
   assign csr_ready  = 1'b1;
   assign s1_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign csr.valid = csr_valid;
   assign csr.index = csr_addr;
   assign csr.data  = csr_wdata;

   // envelope state and registers
   oade_env_step u_step (
      .clock        (clock),
      .reset        (reset),
      .item_accept  (req_xfer),
      .item_op      (req_tuser),
      .csr          (csr),
      .sample_level (sample_level),
      .status       (status)
   );

   // stage register: sample ticks only, note-ons end at the state update
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_xfer && (req_tuser == OP_SAMPLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         for (int i = 0; i < LANES; i++) begin
            s1_sample_ff[i] <= req_tdata[i*SAMPLE_W +: SAMPLE_W];
         end
         s1_level_ff <= sample_level;
      end
   end

   // per-lane scaling, lanes past the channel count read zero
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      if (i < CHANNELS) begin : g_active
         oade_scale u_scale (
            .sample (s1_sample_ff[i]),
            .level  (s1_level_ff),
            .scaled (lane_scaled[i])
         );
      end else begin : g_unused
         assign lane_scaled[i] = '0;
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         rsp_data_in[i*SAMPLE_W +: SAMPLE_W] = lane_scaled[i];
      end
      rsp_data_in[LANES*SAMPLE_W +: LEVEL_W] = s1_level_ff;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `OADE_ASSERT_IMP(a_decay_level_bounded, clock, reset,
      status.phase == PH_DECAY, status.level <= FULL_SCALE)
   `OADE_ASSERT_IMP(a_rsp_level_bounded, clock, reset,
      rsp_valid_ff, rsp_data_ff[LANES*SAMPLE_W +: LEVEL_W] <= FULL_SCALE)
   `OADE_ASSERT_NEXT(a_sample_enters_stage, clock, reset,
      req_xfer && req_tuser == OP_SAMPLE, s1_valid_ff)
   `OADE_ASSERT_NEXT(a_note_on_starts_attack, clock, reset,
      req_xfer && req_tuser == OP_NOTE_ON && status.attack_armed && !csr_valid,
      status.phase == PH_ATTACK)

endmodule

// File: test/onset_attack_decay_envelope_test.sv
module onset_attack_decay_envelope_test
   import oade_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     CLOCK_HALF_NS  = 6;
   localparam int     RESET_CYCLES   = 7;
   localparam int     DRAIN_CYCLES   = 6;
   localparam int     HOLDOFF_CYCLES = 90;
   localparam int     RANDOM_ITEMS   = 540;
   localparam int     MAX_REPORTS    = 10;
   localparam longint WATCHDOG_NS    = 5_000_000;

   // write address with no register behind it
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;

   // one rsp transfer, laid out as on rsp_tdata
   typedef struct packed {
      logic [LEVEL_W-1:0]  level;
      logic [SAMPLE_W-1:0] right;
      logic [SAMPLE_W-1:0] left;
   } scaled_frame_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [STEP_W-1:0]     csr_wdata = '0;

   onset_attack_decay_envelope dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // envelope state and registers as the block should hold them
   phase_type          env_phase;
   logic [LEVEL_W-1:0] env_level;
   logic [STEP_W-1:0]  env_attack_step;
   logic [STEP_W-1:0]  env_decay_step;
   logic [LEVEL_W-1:0] env_onset;

   scaled_frame_type scaled_frame_q[$];

   int unsigned fail_count;
   int unsigned mismatch_count;
   int unsigned items_sent;
   int unsigned note_ons_taken;
   int unsigned frames_checked;
   int unsigned reg_writes;
   int unsigned attack_frames;
   int unsigned decay_frames;
   int unsigned idle_frames;

   // sender burst bookkeeping
   int unsigned burst_left;
   bit          tx_steady;

   // receiver stall pattern and long hold-off
   event        holdoff_start;
   bit          rx_holding;
   int unsigned rx_mode;
   int unsigned rx_mode_left;
   int unsigned rx_tick;

   // clock
   initial begin
      forever #(CLOCK_HALF_NS) clock = ~clock;
   end

   // run limit
   initial begin
      #(WATCHDOG_NS);
      $display("FAIL");
      $finish;
   end

   // sample times q1.23 level, floor shift back to 24 bits
   function automatic logic [SAMPLE_W-1:0] scale_by_level(logic [SAMPLE_W-1:0] smp,
                                                         logic [LEVEL_W-1:0] lvl);
      longint prod;
      prod = longint'(signed'(smp)) * longint'(lvl);
      return SAMPLE_W'(prod >>> FRAC_W);
   endfunction

   // register write as seen by the envelope
   function automatic void apply_reg(logic [CSR_ADDR_W-1:0] idx, logic [STEP_W-1:0] value);
      case (idx)
         CSR_ATTACK_STEP: begin
            env_attack_step = value;
            if (env_phase == PH_ATTACK && value == '0) env_phase = PH_IDLE;
         end
         CSR_DECAY_STEP: begin
            env_decay_step = value;
            if (env_phase == PH_DECAY && value == '0) env_phase = PH_IDLE;
         end
         CSR_ONSET_LEVEL: env_onset = value;
         default: ;
      endcase
   endfunction

   // advance the envelope by one req item; returns 1 when a frame comes out
   function automatic bit envelope_step(op_type op, logic [SAMPLE_W-1:0] left_in,
                                        logic [SAMPLE_W-1:0] right_in,
                                        output scaled_frame_type frame);
      logic [LEVEL_W:0]   sum;
      logic [LEVEL_W-1:0] used;
      frame = '0;
      if (op == OP_NOTE_ON) begin
         if (env_attack_step != '0) begin
            env_level = env_onset;
            env_phase = PH_ATTACK;
         end else if (env_decay_step != '0) begin
            env_level = FULL_SCALE;
            env_phase = PH_DECAY;
         end
         return 1'b0;
      end
      case (env_phase)
         PH_ATTACK: begin
            attack_frames++;
            sum = {1'b0, env_level} + {1'b0, env_attack_step};
            if (sum >= {1'b0, FULL_SCALE}) begin
               env_level = FULL_SCALE;
               env_phase = PH_DECAY;
            end else begin
               env_level = sum[LEVEL_W-1:0];
            end
            used = env_level;
         end
         PH_DECAY: begin
            decay_frames++;
            if (env_level <= env_decay_step) begin
               env_level = '0;
               env_phase = PH_IDLE;
            end else begin
               env_level = env_level - env_decay_step;
            end
            used = env_level;
         end
         default: begin
            idle_frames++;
            used = '0;
         end
      endcase
      frame.left  = scale_by_level(left_in, used);
      frame.right = (CHANNELS_DEFAULT >= 2) ? scale_by_level(right_in, used) : '0;
      frame.level = used;
      return 1'b1;
   endfunction

   // observe transfers at the rising edge: check results, then predict
   always @(posedge clock) begin
      scaled_frame_type got;
      scaled_frame_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = scaled_frame_type'(rsp_tdata);
            if (scaled_frame_q.size() == 0) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: unexpected rsp transfer %h", $realtime, rsp_tdata);
            end else begin
               want = scaled_frame_q.pop_front();
               frames_checked++;
               if (got.left !== want.left || got.right !== want.right ||
                   got.level !== want.level) begin
                  fail_count++;
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display({"%0t: mismatch left exp %h got %h, right exp %h got %h,",
                               " level exp %h got %h"},
                              $realtime, want.left, got.left, want.right, got.right,
                              want.level, got.level);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (op_type'(req_tuser) == OP_NOTE_ON) note_ons_taken++;
            if (envelope_step(op_type'(req_tuser), req_tdata[SAMPLE_W-1:0],
                              req_tdata[2*SAMPLE_W-1:SAMPLE_W], want))
               scaled_frame_q.push_back(want);
         end
         if (csr_valid && csr_ready) begin
            apply_reg(csr_addr, csr_wdata);
            reg_writes++;
         end
      end
   end

   // long receiver hold-off, counted here
   always begin
      @(holdoff_start);
      rx_holding = 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clock);
      rx_holding = 1'b0;
   end

   // receiver stall pattern: always ready, coin flip, periodic, or mostly stalled
   always @(negedge clock) begin
      rx_tick++;
      if (rx_holding) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(8, 64);
         end
         rx_mode_left--;
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= (rx_tick % 4) != 0;
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // offer one item; returns at the edge that takes it, with tvalid still high
   task automatic send_item(op_type op, logic [SAMPLE_W-1:0] left_in,
                            logic [SAMPLE_W-1:0] right_in);
      int unsigned gap;
      @(negedge clock);
      if (!tx_steady) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {right_in, left_in};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // stop offering, wait for every frame, then let the pipeline drain
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (scaled_frame_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // register write, only with the block idle
   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [STEP_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // sample value, leaning on the extremes now and then
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 11))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'hFFFFFF;
         3: return 24'h000000;
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   // step value; mostly fast enough to cross every phase in a few dozen samples
   function automatic logic [STEP_W-1:0] pick_step();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return 24'd1;
         2: return FULL_SCALE;
         3: return 24'hFFFFFF;
         4: return STEP_W'($urandom());
         default: return STEP_W'(FULL_SCALE / $urandom_range(2, 48));
      endcase
   endfunction

   function automatic logic [LEVEL_W-1:0] pick_onset();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return FULL_SCALE;
         2: return 24'hFFFFFF;
         3: return LEVEL_W'($urandom());
         default: return LEVEL_W'($urandom_range(0, FULL_SCALE));
      endcase
   endfunction

   task automatic send_samples(int unsigned count);
      repeat (count) send_item(OP_SAMPLE, pick_sample(), pick_sample());
   endtask

   // idle after reset gives zero frames; reset registers give a slow attack from zero
   task automatic test_reset_defaults();
      send_item(OP_SAMPLE, 24'h800000, 24'h7FFFFF);
      send_item(OP_SAMPLE, 24'h000000, 24'hFFFFFF);
      send_item(OP_NOTE_ON, pick_sample(), pick_sample());
      send_item(OP_SAMPLE, 24'h7FFFFF, 24'h800000);
      send_item(OP_SAMPLE, 24'h800000, 24'h000001);
   endtask

   // attack saturates at full scale, decay clamps at zero, then idle
   task automatic test_attack_to_decay();
      write_reg(CSR_ATTACK_STEP, 24'h400000);
      write_reg(CSR_DECAY_STEP, 24'h4CCCCD);
      write_reg(CSR_ONSET_LEVEL, 24'h400000);
      send_item(OP_NOTE_ON, 24'h7FFFFF, 24'h800000);
      send_item(OP_SAMPLE, 24'h7FFFFF, 24'h800000);
      send_item(OP_SAMPLE, 24'h800000, 24'h7FFFFF);
      send_item(OP_SAMPLE, 24'hFFFFFF, 24'h000001);
      send_item(OP_SAMPLE, 24'h7FFFFF, 24'h7FFFFF);
   endtask

   // onset loaded above full scale is clipped by the first attack step
   task automatic test_onset_above_full();
      write_reg(CSR_ONSET_LEVEL, 24'hFFFFFF);
      write_reg(CSR_ATTACK_STEP, 24'd1);
      write_reg(CSR_DECAY_STEP, FULL_SCALE);
      send_item(OP_NOTE_ON, '0, '0);
      send_item(OP_SAMPLE, 24'h800000, 24'h7FFFFF);
      send_item(OP_SAMPLE, 24'h7FFFFF, 24'h800000);
   endtask

   // widest steps: one sample up, one sample down
   task automatic test_widest_steps();
      write_reg(CSR_ATTACK_STEP, 24'hFFFFFF);
      write_reg(CSR_DECAY_STEP, 24'hFFFFFF);
      write_reg(CSR_ONSET_LEVEL, FULL_SCALE);
      send_item(OP_NOTE_ON, pick_sample(), pick_sample());
      send_item(OP_SAMPLE, 24'h800000, 24'h800000);
      send_item(OP_SAMPLE, 24'h7FFFFF, 24'h7FFFFF);
   endtask

   // attack off starts decay at full scale; both off ignores the note-on
   task automatic test_attack_disabled();
      write_reg(CSR_ATTACK_STEP, '0);
      write_reg(CSR_DECAY_STEP, 24'h200000);
      send_item(OP_NOTE_ON, pick_sample(), pick_sample());
      send_samples(3);
      // still in decay here, so clearing the step also forces idle
      write_reg(CSR_DECAY_STEP, '0);
      send_item(OP_NOTE_ON, pick_sample(), pick_sample());
      send_item(OP_SAMPLE, 24'h7FFFFF, 24'h800000);
   endtask

   // zero written to the active phase's step drops to idle
   task automatic test_step_cleared();
      write_reg(CSR_ATTACK_STEP, 24'h001000);
      write_reg(CSR_DECAY_STEP, 24'h100000);
      write_reg(CSR_ONSET_LEVEL, '0);
      send_item(OP_NOTE_ON, pick_sample(), pick_sample());
      send_samples(1);
      write_reg(CSR_ATTACK_STEP, '0);
      send_samples(1);
      send_item(OP_NOTE_ON, pick_sample(), pick_sample());
      send_samples(1);
      write_reg(CSR_DECAY_STEP, '0);
      send_samples(1);
   endtask

   // write to an address with no register leaves all registers alone
   task automatic test_unused_index();
      write_reg(CSR_ATTACK_STEP, 24'h100000);
      write_reg(CSR_UNUSED, 24'hABCDEF);
      send_item(OP_NOTE_ON, pick_sample(), pick_sample());
      send_samples(1);
   endtask

   // receiver holds off while the sender keeps offering, filling the pipeline
   task automatic test_receiver_holdoff();
      write_reg(CSR_ATTACK_STEP, STEP_W'(FULL_SCALE / 24));
      write_reg(CSR_DECAY_STEP, STEP_W'(FULL_SCALE / 40));
      write_reg(CSR_ONSET_LEVEL, '0);
      tx_steady = 1'b1;
      @(posedge clock);
      -> holdoff_start;
      send_item(OP_NOTE_ON, pick_sample(), pick_sample());
      send_samples(40);
      tx_steady = 1'b0;
   endtask

   // random settings, note-on runs with random content, some noise
   task automatic test_random_stream(int unsigned target);
      int unsigned start_count;
      int unsigned runs;
      start_count = items_sent;
      while (items_sent - start_count < target) begin
         write_reg(CSR_ATTACK_STEP, pick_step());
         write_reg(CSR_DECAY_STEP, pick_step());
         write_reg(CSR_ONSET_LEVEL, pick_onset());
         tx_steady = ($urandom_range(0, 3) == 0);
         runs = $urandom_range(1, 4);
         repeat (runs) begin
            case ($urandom_range(0, 7))
               0: begin
                  // noise: opcodes at random
                  repeat ($urandom_range(1, 10))
                     send_item(op_type'($urandom_range(0, 1)), pick_sample(), pick_sample());
               end
               1: begin
                  // clear a step mid-envelope, then keep ticking
                  send_item(OP_NOTE_ON, pick_sample(), pick_sample());
                  send_samples($urandom_range(1, 12));
                  if ($urandom_range(0, 1))
                     write_reg(CSR_ATTACK_STEP, '0);
                  else
                     write_reg(CSR_DECAY_STEP, '0);
                  send_samples($urandom_range(1, 4));
               end
               default: begin
                  send_item(OP_NOTE_ON, pick_sample(), pick_sample());
                  send_samples($urandom_range(1, 70));
               end
            endcase
         end
         tx_steady = 1'b0;
      end
   endtask

   initial begin
      int unsigned waited;
      env_phase       = PH_IDLE;
      env_level       = '0;
      env_attack_step = ATTACK_STEP_RESET;
      env_decay_step  = DECAY_STEP_RESET;
      env_onset       = ONSET_LEVEL_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_attack_to_decay();
      test_onset_above_full();
      test_widest_steps();
      test_attack_disabled();
      test_step_cleared();
      test_unused_index();
      test_receiver_holdoff();
      test_random_stream(RANDOM_ITEMS);

      // drain: every frame back, then DRAIN_CYCLES quiet cycles
      @(negedge clock);
      req_tvalid <= 1'b0;
      waited = 0;
      while (scaled_frame_q.size() != 0 && waited < 4000) begin
         @(negedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (scaled_frame_q.size() != 0) begin
         fail_count += scaled_frame_q.size();
         $display("%0d expected frames never arrived", scaled_frame_q.size());
      end
      if (mismatch_count > MAX_REPORTS)
         $display("%0d mismatches in total", mismatch_count);

      $display("covered %0d items (%0d note-on), %0d frames compared, %0d register writes",
               items_sent, note_ons_taken, frames_checked, reg_writes);
      $display("frames by phase: attack %0d, decay %0d, idle %0d",
               attack_frames, decay_frames, idle_frames);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/oade_pkg.sv
rtl/core/oade_scale.sv
rtl/core/oade_env_step.sv
rtl/core/onset_attack_decay_envelope.sv
test/onset_attack_decay_envelope_test.sv
